// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/pctd_pkg.sv =====
// shared types, constants and hex helpers of the percent decoder
// no dependencies
package pctd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_9    = 8'h39;
    localparam logic [7:0] CHR_LA   = 8'h61;
    localparam logic [7:0] CHR_LF   = 8'h66;
    localparam logic [7:0] CHR_UA   = 8'h41;
    localparam logic [7:0] CHR_UF   = 8'h46;

    // one classified request: up to three output bytes in order
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       last;
    } pctd_cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_LA && c <= CHR_LF) ||
               (c >= CHR_UA && c <= CHR_UF);
    endfunction

    // digits keep their low nibble, letters of either case add nine
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return (c <= CHR_9) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

endpackage

// ===== hdl/pctd_front.sv =====
// front end: tracks the escape phase and turns each input byte into a request
// depends on pctd_pkg
module pctd_front import pctd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output pctd_cmd_t  cmd
);

    typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [1:0] pre_n;
    logic [7:0] pre0, pre1;
    logic       tail_en;
    logic [7:0] tail_byte;
    logic       run_idle;
    logic       hex;

    always_comb begin
        hex        = is_hex(in_byte);
        phase_next = PH_IDLE;
        held_next  = held_reg;
        pre_n      = 2'd0;
        pre0       = PCT_CHAR;
        pre1       = held_reg;
        tail_en    = 1'b0;
        tail_byte  = in_byte;
        run_idle   = 1'b0;
        unique case (phase_reg)
            PH_PCT: begin
                if (hex) begin
                    held_next = in_byte;
                    if (in_last) begin
                        pre_n   = 2'd1;
                        tail_en = 1'b1;
                    end else begin
                        phase_next = PH_DIGIT;
                    end
                end else begin
                    pre_n    = 2'd1;
                    run_idle = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (hex) begin
                    tail_en   = 1'b1;
                    tail_byte = {hex_val(held_reg), hex_val(in_byte)};
                end else begin
                    pre_n    = 2'd2;
                    run_idle = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase
        if (run_idle) begin
            if (in_byte == PCT_CHAR && !in_last) begin
                phase_next = PH_PCT;
            end else begin
                tail_en = 1'b1;
            end
        end
        if (in_last) begin
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    always_comb begin
        cmd.b0   = (pre_n != 2'd0) ? pre0 : tail_byte;
        cmd.b1   = (pre_n == 2'd2) ? pre1 : tail_byte;
        cmd.b2   = tail_byte;
        cmd.cnt  = pre_n + {1'b0, tail_en};
        cmd.last = in_last;
        push     = accept && (cmd.cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hdl/pctd_queue.sv =====
// small request queue between front end and back end
// depends on pctd_pkg
module pctd_queue import pctd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pctd_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output pctd_cmd_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pctd_cmd_t         mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/pctd_back.sv =====
// back end: walks the bytes of each request into the output register
// depends on pctd_pkg
module pctd_back import pctd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  pctd_cmd_t  head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       final_byte;
    logic [7:0] sel_byte;

    always_comb begin
        load       = !q_empty && (!valid_reg || m_ready);
        final_byte = (idx_reg == head.cnt - 2'd1);
        pop        = load && final_byte;
        case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            default: sel_byte = head.b2;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            last_reg <= final_byte && head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= final_byte ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_last = last_reg;

endmodule

// ===== hdl/percent_decoder_core.sv =====
// top level of the streaming url percent decoder
// depends on pctd_pkg, pctd_front, pctd_queue, pctd_back, assert_macros.svh
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_in_byte[7:0], s_in_last
//  m_      | out       | m_valid / m_ready  | m_out_byte[7:0], m_out_last
//
// one input byte is taken per cycle while the request queue has room
// a byte produces zero to three output bytes, which leave the output register
// at one per cycle while m_ready is high
// a broken escape sequence emits up to three bytes and backs up the queue
// reset is synchronous on aresetn low and clears phase, queue and output valid
// either side may stall freely; the queue of QUEUE_DEPTH requests decouples them
`include "assert_macros.svh"

module percent_decoder_core import pctd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic      accept;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    pctd_cmd_t push_cmd;
    pctd_cmd_t head;

    // the front end only stalls when the queue is full
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // phase tracking and classification of each request
    pctd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push),
        .cmd     (push_cmd)
    );

    // requests waiting for the back end
    pctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // serializes each request onto the output channel
    pctd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    // a final input byte always yields a request
    `ASSERT_SAME(a_last_pushes, aclk, aresetn, accept && s_in_last, push)
    // the queue never takes a request while full
    `ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !q_full)
    // the back end never pops an empty queue
    `ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, !q_empty)

endmodule

// ===== tb/sv/tb_percent_decoder_core.sv =====
// self-checking testbench for percent_decoder_core: directed strings, then random strings
// depends on pctd_pkg (character constants) and the percent_decoder_core rtl
module tb_percent_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pctd_pkg::*;

    // cycles with no request moving on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 1000;
    // approximate number of random input bytes after the directed strings
    localparam int RANDOM_BYTES  = 204;
    // the receiver holds off this long once, after HOLD_AFTER results
    localparam int HOLD_CYCLES   = 60;
    localparam int HOLD_AFTER    = 120;
    // cycles allowed after the last expected byte for stray output
    localparam int DRAIN_CYCLES  = 20;
    // idle chance of either side, in percent
    localparam int IDLE_PCT      = 38;

    // decoder phase as tracked by the predictor
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } dec_phase_t;

    // one byte with its end-of-string flag, used on both channels
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_in_last  = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    // raw bytes still to be offered, front is the one on the bus
    byte_item_t raw_bytes[$];
    // decoded bytes predicted but not yet seen at the output
    byte_item_t decoded_due[$];
    // results of the byte being predicted
    byte_item_t step_bytes[$];

    // predictor state
    dec_phase_t dec_phase  = PH_IDLE;
    logic [7:0] held_char  = 8'h00;

    int err_count    = 0;
    int fed_count    = 0;
    int result_count = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stall_cycles = 0;

    percent_decoder_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_LA && c <= CHR_LF) ||
               (c >= CHR_UA && c <= CHR_UF);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHR_0 && c <= CHR_9)
            v = c - CHR_0;
        else if (c >= CHR_LA && c <= CHR_LF)
            v = c - CHR_LA + 8'd10;
        else
            v = c - CHR_UA + 8'd10;
        return v[3:0];
    endfunction

    function automatic void emit(input logic [7:0] b);
        byte_item_t it;
        it.data = b;
        it.last = 1'b0;
        step_bytes.insert(step_bytes.size(), it);
    endfunction

    // a byte seen with no sequence open; a lone '%' on the final byte passes through
    function automatic void take_from_idle(input logic [7:0] b, input logic last);
        if (b == PCT_CHAR && !last)
            dec_phase = PH_PCT;
        else
            emit(b);
    endfunction

    // advance the predictor by one accepted request and queue its decoded bytes
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        dec_phase_t ph;
        ph = dec_phase;
        dec_phase = PH_IDLE;
        step_bytes.delete();
        case (ph)
            PH_PCT: begin
                if (is_hex_char(b)) begin
                    held_char = b;
                    if (last) begin
                        // "%X" cut short by the end of the string
                        emit(PCT_CHAR);
                        emit(b);
                    end else begin
                        dec_phase = PH_DIGIT;
                    end
                end else begin
                    emit(PCT_CHAR);
                    take_from_idle(b, last);
                end
            end
            PH_DIGIT: begin
                if (is_hex_char(b)) begin
                    emit({nibble_of(held_char), nibble_of(b)});
                end else begin
                    // broken sequence: flush it, then the byte starts afresh
                    emit(PCT_CHAR);
                    emit(held_char);
                    take_from_idle(b, last);
                end
            end
            default: take_from_idle(b, last);
        endcase
        if (last) begin
            dec_phase = PH_IDLE;
            held_char = 8'h00;
            if (step_bytes.size() > 0)
                step_bytes[step_bytes.size() - 1].last = 1'b1;
        end
        foreach (step_bytes[i])
            decoded_due.insert(decoded_due.size(), step_bytes[i]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // append one raw byte to the pending stimulus
    function automatic void add_raw(input logic [7:0] d, input logic l);
        byte_item_t it;
        it.data = d;
        it.last = l;
        raw_bytes.insert(raw_bytes.size(), it);
    endfunction

    // queue a whole string, the final character flagged last
    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_raw(s[i], (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int n;
        n = $urandom_range(0, 21);
        if (n < 10)
            return CHR_0 + 8'(n);
        else if (n < 16)
            return CHR_LA + 8'(n - 10);
        else
            return CHR_UA + 8'(n - 16);
    endfunction

    // one random string: well-formed escapes most often, with broken ones and noise mixed in
    function automatic void queue_random_string();
        logic [7:0] chars[$];
        int tokens;
        int r;
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                chars.insert(chars.size(), PCT_CHAR);
                chars.insert(chars.size(), rand_hex_char());
                chars.insert(chars.size(), rand_hex_char());
            end else if (r < 55) begin
                chars.insert(chars.size(), PCT_CHAR);
                chars.insert(chars.size(), rand_hex_char());
            end else if (r < 62) begin
                chars.insert(chars.size(), PCT_CHAR);
            end else if (r < 75) begin
                chars.insert(chars.size(), rand_hex_char());
            end else begin
                chars.insert(chars.size(), 8'($urandom_range(0, 255)));
            end
        end
        foreach (chars[i])
            add_raw(chars[i], (i == chars.size() - 1));
    endfunction

    // ------------------------------------------------------------------
    // sender: offers the front of raw_bytes, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit calm;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'h00;
            s_in_last <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, s_in_last);
                void'(raw_bytes.pop_front());
                fed_count <= fed_count + 1;
            end
            // a request not yet taken stays on the bus unchanged
            if (!(s_valid && !s_ready)) begin
                // no idling during the full-rate window or while the receiver holds off
                calm = (fed_count >= 40 && fed_count < 100) || hold_left > 0;
                if (raw_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= raw_bytes[0].data;
                    s_in_last <= raw_bytes[0].last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off so the decoder backs up
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && result_count >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= (result_count >= 40 && result_count < 90) ||
                       $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // ------------------------------------------------------------------
    // output check against the oldest predicted byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        byte_item_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count <= result_count + 1;
            if (decoded_due.size() == 0) begin
                $error("out_byte: expected nothing, actual 0x%02h (out_last %0b)",
                       m_out_byte, m_out_last);
                err_count++;
            end else begin
                want = decoded_due.pop_front();
                if (m_out_byte !== want.data) begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, m_out_byte);
                    err_count++;
                end
                if (m_out_last !== want.last) begin
                    $error("out_last: expected %0b, actual %0b", want.last, m_out_last);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any request moving ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int directed_len;

        // complete escape on the final byte, digit and upper case extremes
        queue_text("%A0");
        // lone '%' as the whole string
        queue_text("%");
        // "%X" cut short by the end
        queue_text("%4");
        // broken after one lower-case digit, breaking byte ends the string
        queue_text("%aG");
        // '%' breaks an open sequence and starts a new one, both cases of f
        queue_text("%%fF");
        // '%' breaking "%0" is itself the final byte
        queue_text("%0%");
        // extremes of the byte range
        add_raw(8'h00, 1'b0);
        add_raw(8'hFF, 1'b1);
        // non-hex after a nine, non-hex right after '%'
        queue_text("%9Z");
        queue_text("%Gz");
        // two '%' ending the string
        queue_text("%%");
        directed_len = raw_bytes.size();

        while (raw_bytes.size() < directed_len + RANDOM_BYTES)
            queue_random_string();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // everything offered and accepted, every predicted byte seen
        while (raw_bytes.size() != 0 || s_valid || decoded_due.size() != 0)
            @(negedge aclk);
        // room for any stray output
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
